// File: rtl/siao_pkg.sv
// Shared types, opcodes and result kinds for the small integer ALU.
// No dependencies.
`timescale 1ns / 1ps
package siao_pkg;
  localparam int IntWidth = 16;
  localparam int QueueDepth = 2;
  localparam int DivSteps = IntWidth;

  localparam logic [4:0] OpAdd = 5'd0;
  localparam logic [4:0] OpSub = 5'd1;
  localparam logic [4:0] OpLt = 5'd2;
  localparam logic [4:0] OpGt = 5'd3;
  localparam logic [4:0] OpLe = 5'd4;
  localparam logic [4:0] OpGe = 5'd5;
  localparam logic [4:0] OpEq = 5'd6;
  localparam logic [4:0] OpNe = 5'd7;
  localparam logic [4:0] OpMul = 5'd8;
  localparam logic [4:0] OpQuo = 5'd9;
  localparam logic [4:0] OpRem = 5'd10;
  localparam logic [4:0] OpAnd = 5'd11;
  localparam logic [4:0] OpXor = 5'd12;
  localparam logic [4:0] OpEq2 = 5'd13;
  localparam logic [4:0] OpShift = 5'd19;

  localparam logic [1:0] KindInt = 2'd0;
  localparam logic [1:0] KindTrue = 2'd1;
  localparam logic [1:0] KindFalse = 2'd2;
  localparam logic [1:0] KindNil = 2'd3;

  // Classified word handed from front to back.
  typedef enum logic [3:0] {
    CL_PASS = 4'b0001,
    CL_FIXED = 4'b0010,
    CL_MUL = 4'b0100,
    CL_DIV = 4'b1000
  } cls_t;

  typedef struct packed {
    cls_t cls;
    logic is_rem;
    logic [1:0] kind;
    logic signed [IntWidth-1:0] value;
    logic signed [IntWidth-1:0] a;
    logic signed [IntWidth-1:0] b;
  } word_t;
endpackage

// File: rtl/small_int_alu_with_overflow.sv
// Top level of the small integer ALU: front, queue, back.
// Depends on siao_pkg, siao_front, siao_queue, siao_back.
//
// Input channel in_valid/in_ready carries one word: in_action, in_operand_a,
// in_operand_b. Output channel out_valid/out_ready carries out_result_kind
// (0 int, 1 true, 2 false, 3 nil) and out_result_value.
// Throughput: one word per cycle while the receiver does not stall. Each word
// passes one queue register, one stage for the multiply and sign handling,
// sixteen one-bit divide stages and one result stage. Every op travels the
// same path so results stay in order.
// Reset (rst_n low, synchronous) empties the queue and pipeline.
// When the receiver stalls the back pipeline freezes, the queue fills, and
// in_ready drops once both queue entries are taken.
`timescale 1ns / 1ps
module small_int_alu_with_overflow (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [4:0] in_action,
  input  logic signed [15:0] in_operand_a,
  input  logic signed [15:0] in_operand_b,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] out_result_kind,
  output logic signed [15:0] out_result_value
);
  siao_pkg::word_t fw, qw;
  logic q_valid, q_ready;

  siao_front u_front (.action(in_action), .a(in_operand_a), .b(in_operand_b), .w(fw));

  siao_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(in_valid), .push_ready(in_ready), .push_word(fw),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_word(qw)
  );

  siao_back u_back (
    .clk(clk), .rst_n(rst_n),
    .in_valid(q_valid), .in_ready(q_ready), .in_word(qw),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_result_kind), .out_value(out_result_value)
  );
endmodule

// File: rtl/siao_front.sv
// Front end (combinational): classifies words, evaluates cheap ops, tags mul/div.
// Depends on siao_pkg.
`timescale 1ns / 1ps
module siao_front (
  input  logic [4:0] action,
  input  logic signed [siao_pkg::IntWidth-1:0] a,
  input  logic signed [siao_pkg::IntWidth-1:0] b,
  output siao_pkg::word_t w
);
  localparam int W = siao_pkg::IntWidth;
  logic signed [W:0] sum_x, dif_x;
  logic [W-1:0] shl, shr;
  logic signed [W:0] nb;
  logic cmp_lt, cmp_eq;

  assign sum_x = {a[W-1], a} + {b[W-1], b};
  assign dif_x = {a[W-1], a} - {b[W-1], b};
  assign nb = -{b[W-1], b};
  assign cmp_lt = a < b;
  assign cmp_eq = a == b;
  assign shl = ($signed(b) >= W) ? '0 : (a << b[$clog2(W):0]);
  assign shr = (nb >= W) ? {W{a[W-1]}} : W'(a >>> nb[$clog2(W):0]);

  // Classify and evaluate cheap ops.
  always_comb begin
    w.cls = siao_pkg::CL_FIXED;
    w.is_rem = (action == siao_pkg::OpRem);
    w.kind = siao_pkg::KindInt;
    w.value = a;
    w.a = a;
    w.b = b;
    unique case (action)
      siao_pkg::OpAdd: begin
        w.value = sum_x[W-1:0];
        if (sum_x[W] != sum_x[W-1]) w.kind = siao_pkg::KindNil;
      end
      siao_pkg::OpSub: begin
        w.value = dif_x[W-1:0];
        if (dif_x[W] != dif_x[W-1]) w.kind = siao_pkg::KindNil;
      end
      siao_pkg::OpLt: w.kind = cmp_lt ? siao_pkg::KindTrue : siao_pkg::KindFalse;
      siao_pkg::OpGt: w.kind = (!cmp_lt && !cmp_eq) ? siao_pkg::KindTrue
                                                    : siao_pkg::KindFalse;
      siao_pkg::OpLe: w.kind = (cmp_lt || cmp_eq) ? siao_pkg::KindTrue
                                                  : siao_pkg::KindFalse;
      siao_pkg::OpGe: w.kind = !cmp_lt ? siao_pkg::KindTrue : siao_pkg::KindFalse;
      siao_pkg::OpEq, siao_pkg::OpEq2:
        w.kind = cmp_eq ? siao_pkg::KindTrue : siao_pkg::KindFalse;
      siao_pkg::OpNe: w.kind = !cmp_eq ? siao_pkg::KindTrue : siao_pkg::KindFalse;
      siao_pkg::OpMul: w.cls = siao_pkg::CL_MUL;
      siao_pkg::OpQuo, siao_pkg::OpRem: begin
        if (b == '0 || (a == {1'b1, {(W-1){1'b0}}} && b == '1))
          w.kind = siao_pkg::KindNil;
        else w.cls = siao_pkg::CL_DIV;
      end
      siao_pkg::OpAnd: w.value = a & b;
      siao_pkg::OpXor: w.value = a ^ b;
      siao_pkg::OpShift: w.value = b[W-1] ? shr : shl;
      default: w.cls = siao_pkg::CL_PASS;
    endcase
    if (w.kind != siao_pkg::KindInt) w.value = '0;
  end
endmodule

// File: rtl/siao_queue.sv
// Short word queue between front and back.
// Depends on siao_pkg.
`timescale 1ns / 1ps
module siao_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  siao_pkg::word_t push_word,
  output logic pop_valid,
  input  logic pop_ready,
  output siao_pkg::word_t pop_word
);
  siao_pkg::word_t mem_r [siao_pkg::QueueDepth];
  logic wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic push, pop;

  assign push_ready = cnt_r != 2'(siao_pkg::QueueDepth);
  assign pop_valid = cnt_r != '0;
  assign pop_word = mem_r[rp_r];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign wp_nxt = push ? !wp_r : wp_r;
  assign rp_nxt = pop ? !rp_r : rp_r;
  assign cnt_nxt = cnt_r + 2'(push) - 2'(pop);

  // Advance pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store words.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_word;
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(siao_pkg::QueueDepth)) else $error("queue overflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1) else $error("count slip");
  a_cnt_dn: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> cnt_r == $past(cnt_r) - 2'd1) else $error("count slip on pop");
endmodule

// File: rtl/siao_back.sv
// Back end: pipelined multiplier and restoring divider, one word per cycle unless stalled.
// Depends on siao_pkg.
`timescale 1ns / 1ps
module siao_back (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  siao_pkg::word_t in_word,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] out_kind,
  output logic signed [siao_pkg::IntWidth-1:0] out_value
);
  localparam int W = siao_pkg::IntWidth;
  localparam int S = siao_pkg::DivSteps + 2;

  typedef struct packed {
    siao_pkg::cls_t cls;
    logic is_rem;
    logic [1:0] kind;
    logic [W-1:0] value;
    logic [W-1:0] rem;
    logic [W-1:0] quo;
    logic [W-1:0] dvs;
    logic neg_q;
    logic neg_r;
    logic signed [2*W-1:0] prod;
  } st_t;

  st_t st_r [S];
  logic vld_r [S];
  logic adv;
  st_t s0;

  assign adv = !vld_r[S-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[S-1];

  // Stage zero: magnitudes and product.
  always_comb begin
    s0 = '0;
    s0.cls = in_word.cls;
    s0.is_rem = in_word.is_rem;
    s0.kind = in_word.kind;
    s0.value = in_word.value;
    s0.quo = in_word.a[W-1] ? W'(-in_word.a) : in_word.a;
    s0.dvs = in_word.b[W-1] ? W'(-in_word.b) : in_word.b;
    s0.neg_q = in_word.a[W-1] ^ in_word.b[W-1];
    s0.neg_r = in_word.a[W-1];
    s0.prod = in_word.a * in_word.b;
  end

  // Advance the pipeline; one divide bit per stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < S; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < S; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= s0;
      for (int i = 1; i < S - 1; i++) begin
        logic [W:0] t;
        t = {st_r[i-1].rem, st_r[i-1].quo[W-1]};
        st_r[i] <= st_r[i-1];
        if (t >= {1'b0, st_r[i-1].dvs}) begin
          st_r[i].rem <= W'(t - {1'b0, st_r[i-1].dvs});
          st_r[i].quo <= {st_r[i-1].quo[W-2:0], 1'b1};
        end else begin
          st_r[i].rem <= t[W-1:0];
          st_r[i].quo <= {st_r[i-1].quo[W-2:0], 1'b0};
        end
      end
      // Final stage: resolve the result.
      st_r[S-1] <= st_r[S-2];
      unique case (st_r[S-2].cls)
        siao_pkg::CL_MUL: begin
          if (st_r[S-2].prod[2*W-1:W-1] != '0 && st_r[S-2].prod[2*W-1:W-1] != '1) begin
            st_r[S-1].kind <= siao_pkg::KindNil;
            st_r[S-1].value <= '0;
          end else st_r[S-1].value <= st_r[S-2].prod[W-1:0];
        end
        siao_pkg::CL_DIV: begin
          if (st_r[S-2].is_rem)
            st_r[S-1].value <= st_r[S-2].neg_r ? W'(-st_r[S-2].rem) : st_r[S-2].rem;
          else
            st_r[S-1].value <= st_r[S-2].neg_q ? W'(-st_r[S-2].quo) : st_r[S-2].quo;
        end
        default: ;
      endcase
    end
  end

  assign out_kind = st_r[S-1].kind;
  assign out_value = st_r[S-1].value;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_value)) else $error("hold");
  a_nil0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != siao_pkg::KindInt) |-> out_value == '0) else $error("nil");
  a_kind_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_kind)) else $error("kind hold");
endmodule
